// File: sv/truncated_window_convolution_2d_unit_defines.svh
// Assertion macros shared by the convolution unit RTL
`ifndef TRUNCATED_WINDOW_CONVOLUTION_2D_UNIT_DEFINES_SVH
`define TRUNCATED_WINDOW_CONVOLUTION_2D_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define TWC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define TWC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define TWC_ASSERT(lbl, prop, msg)
`define TWC_NEVER(lbl, cond, msg)
`endif
`endif

// File: sv/twc2d_pkg.sv
// Package: constants, codes and control types of the convolution unit
`default_nettype none
package twc2d_pkg;
  localparam int unsigned MaxWidthDef  = 1024;
  localparam int unsigned MaxKernelDef = 7;
  localparam int unsigned HeightLimit  = 1024;
  localparam int unsigned RowCntW      = 10;
  localparam int unsigned CfgW         = 11;
  localparam int unsigned SlotW        = 3;
  localparam int unsigned SampleW      = 16;
  localparam int unsigned FracBits     = 14;
  localparam int unsigned RoundBias    = 8192;
  localparam int unsigned OutW         = 24;

  typedef enum logic [1:0] {
    CfgImageWidth  = 2'd0,
    CfgImageHeight = 2'd1,
    CfgKernelWidth = 2'd2,
    CfgKernelHeight = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    ModeCoef   = 1'b0,
    ModeSample = 1'b1
  } mode_e;

  typedef struct packed {
    logic               valid;
    logic               sample;
    logic               emit;
    logic               last;
    logic [SlotW-1:0]   base;
    logic [SlotW-1:0]   kw;
    logic [SlotW-1:0]   kh;
    logic [5:0]         cidx;
    logic [SampleW-1:0] cval;
  } mac_ctl_t;
endpackage
`default_nettype wire

// File: sv/twc2d_mac.sv
// Coefficient store, multiply stage, adder tree, rounding and saturation
`default_nettype none
module twc2d_mac #(
  parameter int unsigned MAX_KERNEL = twc2d_pkg::MaxKernelDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  twc2d_pkg::mac_ctl_t           ctl_i,
  input  logic [MAX_KERNEL-1:0][MAX_KERNEL*twc2d_pkg::SampleW-1:0] win_i,
  output logic                          res_valid_o,
  output logic                          res_last_o,
  output logic [twc2d_pkg::OutW-1:0]    res_value_o
);
  import twc2d_pkg::*;

  localparam int unsigned NCoef   = MAX_KERNEL * MAX_KERNEL;
  localparam int unsigned ProdW   = 2 * SampleW;
  localparam int unsigned RowSumW = ProdW + $clog2(MAX_KERNEL) + 1;
  localparam int unsigned TotW    = RowSumW + $clog2(MAX_KERNEL) + 1;
  localparam logic signed [TotW-1:0] OutMax = TotW'((1 << (OutW - 1)) - 1);
  localparam logic signed [TotW-1:0] OutMin = -TotW'(1 << (OutW - 1));

  logic signed [SampleW-1:0] coef_q [NCoef];
  logic signed [ProdW-1:0]   prod_d [MAX_KERNEL][MAX_KERNEL];
  logic signed [ProdW-1:0]   prod_q [MAX_KERNEL][MAX_KERNEL];
  logic signed [RowSumW-1:0] rsum_d [MAX_KERNEL];
  logic signed [RowSumW-1:0] rsum_q [MAX_KERNEL];
  logic signed [TotW-1:0]    tot_d, tot_q, shr;
  logic                      v3_q, l3_q, v4_q, l4_q, v5_q, l5_q;
  logic                      res_valid_q, res_last_q;
  logic [OutW-1:0]           res_value_q, res_value_d;

  always_comb begin
    logic [SlotW:0]          sl;
    logic [SlotW-1:0]        slot;
    logic [SlotW:0]          col;
    logic signed [SampleW-1:0] smp;
    for (int q = 0; q < MAX_KERNEL; q++) begin
      sl = {1'b0, ctl_i.base} + (SlotW+1)'(q);
      if (sl >= (SlotW+1)'(MAX_KERNEL)) sl = sl - (SlotW+1)'(MAX_KERNEL);
      slot = sl[SlotW-1:0];
      for (int p = 0; p < MAX_KERNEL; p++) begin
        col = {1'b0, ctl_i.kw} - (SlotW+1)'(p + 1);
        smp = $signed(win_i[col[SlotW-1:0]][slot*SampleW +: SampleW]);
        if ((SlotW+1)'(p) < {1'b0, ctl_i.kw} && (SlotW+1)'(q) < {1'b0, ctl_i.kh})
          prod_d[q][p] = smp * coef_q[q*MAX_KERNEL+p];
        else
          prod_d[q][p] = '0;
      end
    end
  end

  always_comb begin
    for (int q = 0; q < MAX_KERNEL; q++) begin
      rsum_d[q] = '0;
      for (int p = 0; p < MAX_KERNEL; p++) rsum_d[q] = rsum_d[q] + RowSumW'(prod_q[q][p]);
    end
    tot_d = TotW'(RoundBias);
    for (int q = 0; q < MAX_KERNEL; q++) tot_d = tot_d + TotW'(rsum_q[q]);
  end

  always_comb begin
    shr = tot_q >>> FracBits;
    if (shr > OutMax)      res_value_d = OutMax[OutW-1:0];
    else if (shr < OutMin) res_value_d = OutMin[OutW-1:0];
    else                   res_value_d = shr[OutW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCoef; i++) coef_q[i] <= '0;
    end else if (adv_i && ctl_i.valid && !ctl_i.sample && 32'(ctl_i.cidx) < NCoef) begin
      coef_q[ctl_i.cidx] <= $signed(ctl_i.cval);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0; l3_q <= 1'b0; v4_q <= 1'b0; l4_q <= 1'b0;
      v5_q <= 1'b0; l5_q <= 1'b0; res_valid_q <= 1'b0; res_last_q <= 1'b0;
    end else if (adv_i) begin
      v3_q <= ctl_i.valid && ctl_i.sample && ctl_i.emit;
      l3_q <= ctl_i.last;
      v4_q <= v3_q; l4_q <= l3_q;
      v5_q <= v4_q; l5_q <= l4_q;
      res_valid_q <= v5_q; res_last_q <= l5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q      <= prod_d;
      rsum_q      <= rsum_d;
      tot_q       <= tot_d;
      res_value_q <= res_value_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_last_o  = res_last_q;
  assign res_value_o = res_value_q;
endmodule
`default_nettype wire

// File: sv/truncated_window_convolution_2d_unit.sv
// Top level: 2-D valid correlation over a raster sample stream
// Usage:
//  Slave stream carries coefficient writes (tuser = 0) and image samples
//  (tuser = 1) in raster order; the master stream carries one rounded, saturated
//  sum per valid window clear of the last column and row; tlast on the frame's last.
//  Sizes are set through the cfg write port while the unit is idle.
//  Throughput: one item per clock while results are taken. A line store of
//  MAX_WIDTH words, each word one column of the last MAX_KERNEL rows, is read
//  and written back once per sample; a same-column read right behind a write
//  is forwarded. Items pass the stage-1, stage-2, product, row-sum, total and
//  output registers to tvalid. When the receiver stalls, the whole pipeline
//  holds and s_axis_tready drops only while a result waits and tready is low.
//  Reset clears counters, coefficients and the sizes (1024 x 1024, 3 x 3);
//  the line store is not cleared and needs no clearing pass.
`default_nettype none
`include "truncated_window_convolution_2d_unit_defines.svh"
module truncated_window_convolution_2d_unit #(
  parameter int unsigned MAX_WIDTH  = twc2d_pkg::MaxWidthDef,
  parameter int unsigned MAX_KERNEL = twc2d_pkg::MaxKernelDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [10:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // coef_index[5:0], coef_value[21:6], sample[37:22]
  input  logic [0:0]  s_axis_tuser,   // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // filtered_value
  output logic        m_axis_tlast
);
  import twc2d_pkg::*;

  localparam int unsigned AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CW0   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned WW    = ((CW0 > CfgW) ? CW0 : CfgW) + 1;
  localparam int unsigned WordW = MAX_KERNEL * SampleW;

  logic [CfgW-1:0]    cfg_w_q, cfg_h_q;
  logic [SlotW-1:0]   cfg_kw_q, cfg_kh_q;
  logic [AW-1:0]      col_q;
  logic [RowCntW-1:0] row_q;
  logic [SlotW-1:0]   slot_q;

  logic [WW-1:0]      w, h, wz, hz, xp1, yp1;
  logic [SlotW-1:0]   kw, kh, base;
  logic [SlotW:0]     bsum;
  logic               adv, acc, is_smp, emit, last, wr_en, res_valid;
  mac_ctl_t           s1_ctl_q, s2_ctl_q;
  logic [AW-1:0]      s1_x_q;
  logic [SlotW-1:0]   s1_slot_q;
  logic [SampleW-1:0] s1_data_q;
  logic               s1_fwd_q;

  logic [WordW-1:0]   mem [MAX_WIDTH];
  logic [WordW-1:0]   rd_q, wr_word_q, col_in, merged;
  logic [MAX_KERNEL-1:0][WordW-1:0] win_q;

  assign adv           = !res_valid || m_axis_tready;
  assign s_axis_tready = adv;
  assign acc           = s_axis_tvalid && adv;
  assign is_smp        = (s_axis_tuser[0] == ModeSample);
  assign m_axis_tvalid = res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q  <= CfgW'(1024);
      cfg_h_q  <= CfgW'(1024);
      cfg_kw_q <= SlotW'(3);
      cfg_kh_q <= SlotW'(3);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CfgImageWidth:   cfg_w_q  <= cfg_data_i;
        CfgImageHeight:  cfg_h_q  <= cfg_data_i;
        CfgKernelWidth:  cfg_kw_q <= cfg_data_i[SlotW-1:0];
        CfgKernelHeight: cfg_kh_q <= cfg_data_i[SlotW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w   = (WW'(cfg_w_q) > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(cfg_w_q);
    h   = (WW'(cfg_h_q) > WW'(HeightLimit)) ? WW'(HeightLimit) : WW'(cfg_h_q);
    kw  = (cfg_kw_q > SlotW'(MAX_KERNEL)) ? SlotW'(MAX_KERNEL) : cfg_kw_q;
    kh  = (cfg_kh_q > SlotW'(MAX_KERNEL)) ? SlotW'(MAX_KERNEL) : cfg_kh_q;
    wz  = (w == '0) ? WW'(1) : w;
    hz  = (h == '0) ? WW'(1) : h;
    xp1 = WW'(col_q) + WW'(1);
    yp1 = WW'(row_q) + WW'(1);
    emit = (kw != '0) && (kh != '0) && (w > WW'(kw)) && (h > WW'(kh)) &&
           (xp1 >= WW'(kw)) && (xp1 < w) && (yp1 >= WW'(kh)) && (yp1 < h);
    last = (xp1 + WW'(1) == w) && (yp1 + WW'(1) == h);
    bsum = {1'b0, slot_q} + (SlotW+1)'(MAX_KERNEL) + (SlotW+1)'(1) - {1'b0, kh};
    if (bsum >= (SlotW+1)'(MAX_KERNEL)) bsum = bsum - (SlotW+1)'(MAX_KERNEL);
    base = bsum[SlotW-1:0];
  end

  // raster position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
    end else if (acc && is_smp) begin
      if (xp1 >= wz) begin
        col_q <= '0;
        if (yp1 >= hz) begin
          row_q  <= '0;
          slot_q <= '0;
        end else begin
          row_q  <= row_q + RowCntW'(1);
          slot_q <= (slot_q == SlotW'(MAX_KERNEL - 1)) ? '0 : slot_q + SlotW'(1);
        end
      end else begin
        col_q <= xp1[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= '0;
      s2_ctl_q <= '0;
    end else if (adv) begin
      s2_ctl_q <= s1_ctl_q;
      s1_ctl_q.valid  <= acc;
      s1_ctl_q.sample <= is_smp;
      s1_ctl_q.emit   <= emit;
      s1_ctl_q.last   <= last;
      s1_ctl_q.base   <= base;
      s1_ctl_q.kw     <= kw;
      s1_ctl_q.kh     <= kh;
      s1_ctl_q.cidx   <= s_axis_tdata[5:0];
      s1_ctl_q.cval   <= s_axis_tdata[21:6];
    end
  end

  assign wr_en = s1_ctl_q.valid && s1_ctl_q.sample && adv;

  always_comb begin
    col_in = s1_fwd_q ? wr_word_q : rd_q;
    for (int k = 0; k < MAX_KERNEL; k++)
      merged[k*SampleW +: SampleW] = (SlotW'(k) == s1_slot_q) ? s1_data_q
                                                               : col_in[k*SampleW +: SampleW];
  end

  // line store: one column of the last rows per word
  always_ff @(posedge clk_i) begin
    if (acc && is_smp) rd_q <= mem[col_q];
    if (wr_en) mem[s1_x_q] <= merged;
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_x_q    <= col_q;
      s1_slot_q <= slot_q;
      s1_data_q <= s_axis_tdata[37:22];
      s1_fwd_q  <= wr_en && (s1_x_q == col_q);
    end
    if (wr_en) begin
      wr_word_q <= merged;
      win_q[0]  <= merged;
      for (int c = 1; c < MAX_KERNEL; c++) win_q[c] <= win_q[c-1];
    end
  end

  twc2d_mac #(
    .MAX_KERNEL (MAX_KERNEL)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .ctl_i       (s2_ctl_q),
    .win_i       (win_q),
    .res_valid_o (res_valid),
    .res_last_o  (m_axis_tlast),
    .res_value_o (m_axis_tdata)
  );

  `TWC_ASSERT(a_fwd_after_write, s1_ctl_q.valid && s1_ctl_q.sample && s1_fwd_q |-> $past(wr_en), "forward without write")
  `TWC_NEVER(a_col_range, col_q > AW'(MAX_WIDTH - 1), "column count out of range")
  `TWC_ASSERT(a_slot_track, 32'(slot_q) == 32'(row_q) % MAX_KERNEL, "row slot lost track")
endmodule
`default_nettype wire

// File: tb/testbench.sv
// Stream testbench for the 2-D valid correlation unit with a self-checking predictor
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import twc2d_pkg::*;

  typedef struct {
    mode_e       mode;
    logic [5:0]  idx;
    logic [15:0] cval;
    logic [15:0] smp;
  } request_t;

  typedef struct {
    logic [23:0] value;
    logic        last;
  } window_sum_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [10:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  truncated_window_convolution_2d_unit u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  always #2 clk_i = ~clk_i;

  request_t    pending_q[$];
  window_sum_t sums_q[$];
  int unsigned send_idle = 26;
  int unsigned recv_idle = 75;
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  bit          took = 1'b0;

  // predictor state
  int unsigned   img_w = 1024, img_h = 1024, ker_w = 3, ker_h = 3;
  logic [15:0]   coefs[49];
  logic [15:0]   lines[7][1024];
  int unsigned   col = 0, row = 0;

  initial foreach (coefs[i]) coefs[i] = '0;

  function automatic void predict_sum(request_t rq);
    int unsigned w, h, kw, kh, x, y, x0, y0;
    longint sum, r;
    window_sum_t e;
    if (rq.mode == ModeCoef) begin
      if (rq.idx < 49) coefs[rq.idx] = rq.cval;
      return;
    end
    w = img_w > 1024 ? 1024 : img_w;
    h = img_h > 1024 ? 1024 : img_h;
    kw = ker_w > 7 ? 7 : ker_w;
    kh = ker_h > 7 ? 7 : ker_h;
    x = col;
    y = row;
    lines[y % 7][x] = rq.smp;
    if (kw >= 1 && kh >= 1 && w > kw && h > kh &&
        x + 1 >= kw && x + 1 < w && y + 1 >= kh && y + 1 < h) begin
      sum = 0;
      x0 = x + 1 - kw;
      y0 = y + 1 - kh;
      for (int q = 0; q < kh; q++)
        for (int p = 0; p < kw; p++)
          sum += longint'($signed(lines[(y0 + q) % 7][x0 + p])) *
                 longint'($signed(coefs[q * 7 + p]));
      r = (sum + longint'(RoundBias)) >>> FracBits;
      if (r > 8388607) r = 8388607;
      if (r < -8388608) r = -8388608;
      e.value = r[23:0];
      e.last = (x + 2 == w && y + 2 == h);
      sums_q.push_back(e);
    end
    if (w == 0) w = 1;
    if (h == 0) h = 1;
    if (x + 1 >= w) begin
      col = 0;
      row = (y + 1 >= h) ? 0 : y + 1;
    end else begin
      col = x + 1;
    end
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!(s_axis_tvalid && !took)) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {2'b00, pending_q[0].smp, pending_q[0].cval, pending_q[0].idx};
          s_axis_tuser  <= pending_q[0].mode;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= $urandom_range(99) >= recv_idle;
    end
  end

  always @(posedge clk_i) begin
    window_sum_t e;
    took = s_axis_tvalid && s_axis_tready;
    if (took) predict_sum(pending_q.pop_front());
    if (m_axis_tvalid && m_axis_tready) begin
      if (sums_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result %h last %b", m_axis_tdata, m_axis_tlast);
      end else begin
        e = sums_q.pop_front();
        if (m_axis_tdata !== e.value || m_axis_tlast !== e.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %h last %b, got %h last %b",
                     e.value, e.last, m_axis_tdata, m_axis_tlast);
        end
      end
    end
  end

  task automatic drain();
    while (pending_q.size() > 0 || sums_q.size() > 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_reg_e r, logic [10:0] d);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = r;
    cfg_data_i = d;
    case (r)
      CfgImageWidth:  img_w = d;
      CfgImageHeight: img_h = d;
      CfgKernelWidth: ker_w = d[2:0];
      default:        ker_h = d[2:0];
    endcase
  endtask

  task automatic push(mode_e m, logic [5:0] i, logic [15:0] c, logic [15:0] s);
    request_t rq;
    rq.mode = m;
    rq.idx  = i;
    rq.cval = c;
    rq.smp  = s;
    pending_q.push_back(rq);
    items_sent++;
  endtask

  task automatic run_frames(logic [10:0] w, logic [10:0] h, int kw, int kh,
                            int frames, bit noise);
    int unsigned ew, eh;
    drain();
    write_cfg(CfgImageWidth, w);
    write_cfg(CfgImageHeight, h);
    write_cfg(CfgKernelWidth, {8'($urandom_range(255)), 3'(kw)});
    write_cfg(CfgKernelHeight, {8'($urandom_range(255)), 3'(kh)});
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    for (int i = 0; i < 49; i++)
      if ($urandom_range(3) != 0) push(ModeCoef, 6'(i), 16'($urandom), 16'($urandom));
    push(ModeCoef, 6'($urandom_range(49, 63)), 16'($urandom), 16'($urandom));
    ew = w > 1024 ? 1024 : (w == 0 ? 1 : w);
    eh = h > 1024 ? 1024 : (h == 0 ? 1 : h);
    for (int f = 0; f < frames; f++)
      for (int n = 0; n < ew * eh; n++) begin
        if (noise && $urandom_range(19) == 0)
          push(ModeCoef, 6'($urandom_range(63)), 16'($urandom), 16'($urandom));
        push(ModeSample, 6'($urandom), 16'($urandom), 16'($urandom));
      end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // directed: coefficient extremes, out-of-range index, sample extremes
    write_cfg(CfgImageWidth, 11'd4);
    write_cfg(CfgImageHeight, 11'd3);
    write_cfg(CfgKernelWidth, 11'd2);
    write_cfg(CfgKernelHeight, 11'd2);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    push(ModeCoef, 6'd0, 16'h7fff, 16'h0);
    push(ModeCoef, 6'd1, 16'h8000, 16'h0);
    push(ModeCoef, 6'd7, 16'h8000, 16'h0);
    push(ModeCoef, 6'd8, 16'h4000, 16'h0);
    push(ModeCoef, 6'd63, 16'hffff, 16'hffff);
    push(ModeCoef, 6'd48, 16'hffff, 16'h0);
    for (int n = 0; n < 12; n++)
      push(ModeSample, 6'h3f, 16'hffff, n[0] ? 16'h8000 : 16'h7fff);
    // degenerate sizes: no results, zero width, zero kernel
    run_frames(11'd4, 11'd4, 7, 7, 1, 0);
    run_frames(11'd0, 11'd3, 1, 1, 2, 0);
    run_frames(11'd5, 11'd4, 0, 2, 1, 0);
    while (items_sent < 600) begin
      if (items_sent > 440) begin
        send_idle = 0;
        recv_idle = 0;
      end else if (items_sent > 220) begin
        send_idle = 75;
        recv_idle = 26;
      end
      run_frames(11'($urandom_range(2, 12)), 11'($urandom_range(2, 10)),
                 $urandom_range(1, 7), $urandom_range(1, 7), $urandom_range(1, 2), 1);
    end
    send_idle = 0;
    recv_idle = 0;
    // largest kernels on long rows and tall columns
    run_frames(11'd96, 11'd2, 7, 1, 1, 0);
    run_frames(11'd2, 11'd80, 1, 7, 1, 0);
    drain();
    if (errors == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

  initial begin
    #4ms;
    $display("testbench: done, errors");
    $finish;
  end
endmodule
`default_nettype wire
